// ===== src/lru_page_replacement_top_macros.svh =====
// Assertion macros shared by the LRU page replacement checker
`ifndef LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH

// Check on every clock edge outside reset
`define LRU_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define LRU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lru_pr_pkg.sv =====
// Shared constants and types for the LRU page replacement block
package lru_pr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    localparam int PAGE_PORT_W   = 16;
    localparam int SLOT_PORT_W   = 3;
    localparam int CFG_W         = 4;
    localparam int FAULT_W       = 32;

    // Top level sequencer: normal running, or rank compaction after a config write
    typedef enum logic [1:0] {
        ST_RUN,
        ST_LOAD,
        ST_SWEEP,
        ST_WRITE
    } state_t;

    // Priority flags rippling along the frame row
    typedef struct packed {
        logic hit;
        logic empty;
        logic lru;
    } chain_t;

    // Update command broadcast to every frame cell
    typedef struct packed {
        logic update;
        logic promote;
        logic clear_all;
    } cmd_t;

    // Rank compaction control
    typedef struct packed {
        logic load;
        logic shift;
        logic write;
    } sweep_t;

endpackage

// ===== src/lru_pr_cell.sv =====
// One frame cell: resident page, valid bit, recency rank and compaction stage
module lru_pr_cell #(
    parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF,
    parameter int CELL_IDX  = 0,
    localparam int SLOT_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int CNT_W    = $clog2(FRAMES + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [CNT_W-1:0]        active,
    input  logic                    cfg_we,
    input  logic [CNT_W-1:0]        cfg_active,
    input  logic [PAGE_BITS-1:0]    page_q,
    input  lru_pr_pkg::chain_t      chain_in,
    input  logic [SLOT_W-1:0]       hit_slot_in,
    input  logic [SLOT_W-1:0]       hit_rank_in,
    input  logic [SLOT_W-1:0]       empty_slot_in,
    input  logic [SLOT_W-1:0]       lru_slot_in,
    input  logic [PAGE_BITS-1:0]    lru_page_in,
    output lru_pr_pkg::chain_t      chain_out,
    output logic [SLOT_W-1:0]       hit_slot_out,
    output logic [SLOT_W-1:0]       hit_rank_out,
    output logic [SLOT_W-1:0]       empty_slot_out,
    output logic [SLOT_W-1:0]       lru_slot_out,
    output logic [PAGE_BITS-1:0]    lru_page_out,
    input  lru_pr_pkg::cmd_t        cmd,
    input  logic [SLOT_W-1:0]       cmd_slot,
    input  logic [SLOT_W-1:0]       cmd_old_rank,
    input  logic [SLOT_W-1:0]       cmd_new_rank,
    input  lru_pr_pkg::sweep_t      sweep,
    input  logic                    circ_valid_in,
    input  logic [SLOT_W-1:0]       circ_rank_in,
    output logic                    circ_valid_out,
    output logic [SLOT_W-1:0]       circ_rank_out
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_IDX);
    localparam logic [CNT_W-1:0]  MY_POS  = CNT_W'(CELL_IDX);

    logic                 valid_reg, valid_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic [SLOT_W-1:0]    rank_reg, rank_next;
    logic                 circ_valid_reg, circ_valid_next;
    logic [SLOT_W-1:0]    circ_rank_reg, circ_rank_next;
    logic [SLOT_W-1:0]    acc_reg, acc_next;

    logic match, empty, lru, take_hit, take_empty, take_lru, selected;

    assign match    = valid_reg && (page_reg == page_q);
    assign empty    = !valid_reg && (MY_POS < active);
    assign lru      = valid_reg && (rank_reg == '0);
    assign selected = cmd.update && (cmd_slot == MY_SLOT);

    // First match wins: pass on what has been seen to the right
    assign take_hit   = match && !chain_in.hit;
    assign take_empty = empty && !chain_in.empty;
    assign take_lru   = lru && !chain_in.lru;

    assign chain_out.hit   = chain_in.hit   || match;
    assign chain_out.empty = chain_in.empty || empty;
    assign chain_out.lru   = chain_in.lru   || lru;

    assign hit_slot_out   = hit_slot_in   | (take_hit   ? MY_SLOT  : '0);
    assign hit_rank_out   = hit_rank_in   | (take_hit   ? rank_reg : '0);
    assign empty_slot_out = empty_slot_in | (take_empty ? MY_SLOT  : '0);
    assign lru_slot_out   = lru_slot_in   | (take_lru   ? MY_SLOT  : '0);
    assign lru_page_out   = lru_page_in   | (take_lru   ? page_reg : '0);

    assign circ_valid_out = circ_valid_reg;
    assign circ_rank_out  = circ_rank_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (cfg_we && (MY_POS >= cfg_active))
        begin
            valid_next = 1'b0;
        end
        else if (cmd.clear_all)
        begin
            valid_next = 1'b0;
        end
        else if (selected)
        begin
            valid_next = 1'b1;
        end
    end

    always_comb
    begin
        page_next = page_reg;
        rank_next = rank_reg;
        if (selected)
        begin
            page_next = page_q;
        end
        if (sweep.write && valid_reg)
        begin
            rank_next = acc_reg;
        end
        else if (selected)
        begin
            rank_next = cmd_new_rank;
        end
        else if (cmd.promote && valid_reg && (rank_reg > cmd_old_rank))
        begin
            // close the gap left by the promoted frame
            rank_next = rank_reg - 1'b1;
        end
    end

    // Ring of ranks: every cell sees every rank once over a full sweep
    always_comb
    begin
        circ_valid_next = circ_valid_reg;
        circ_rank_next  = circ_rank_reg;
        acc_next        = acc_reg;
        if (sweep.load)
        begin
            circ_valid_next = valid_reg;
            circ_rank_next  = rank_reg;
            acc_next        = '0;
        end
        else if (sweep.shift)
        begin
            circ_valid_next = circ_valid_in;
            circ_rank_next  = circ_rank_in;
            if (circ_valid_reg && (circ_rank_reg < rank_reg))
            begin
                acc_next = acc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg       <= page_next;
        rank_reg       <= rank_next;
        circ_valid_reg <= circ_valid_next;
        circ_rank_reg  <= circ_rank_next;
        acc_reg        <= acc_next;
    end

endmodule

// ===== src/lru_page_replacement_top.sv =====
// LRU page replacement: fully associative frame row with least recently used eviction
//
// Input channel (in_valid/in_ready) carries one page reference per transfer, with
// last_of_string marking the end of a reference string. Output channel
// (out_valid/out_ready) returns one result per reference: hit, frame slot, evicted
// page, running fault total and the string_done echo.
// Each reference is captured in the input register, and its result in the output register.
// Throughput: one reference per cycle unless the receiver stalls or a compaction runs;
// the whole frame row is compared and its recency ranks updated in the same cycle.
// When the receiver stalls, the finished result holds in the output register, the
// next reference waits in the input register and in_ready drops until the result
// is taken.
// A write to active_frames (cfg_we/cfg_wdata) drops frames at or above the new count
// and renumbers the ranks left: in_ready is low through the load, sweep and write
// states while the ranks circulate once round the row.
// Reset empties every frame, clears the fault total and sets active_frames to
// FRAMES; the block takes references in the first cycle after reset.
module lru_page_replacement_top #(
    parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF,
    localparam int SLOT_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int CNT_W    = $clog2(FRAMES + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lru_pr_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lru_pr_pkg::PAGE_PORT_W-1:0]  page_number,
    input  logic                                last_of_string,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic [lru_pr_pkg::SLOT_PORT_W-1:0]  frame_slot,
    output logic                                evicted_valid,
    output logic [lru_pr_pkg::PAGE_PORT_W-1:0]  evicted_page,
    output logic [lru_pr_pkg::FAULT_W-1:0]      fault_total,
    output logic                                string_done
);

    localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(FRAMES - 1);

    lru_pr_pkg::state_t state_reg, state_next;
    lru_pr_pkg::sweep_t sweep;
    lru_pr_pkg::cmd_t   cmd;

    logic [SLOT_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]   cnt_acc_reg, cnt_acc_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   active_reg, active_next;
    logic [CNT_W-1:0]   cfg_active;
    logic [lru_pr_pkg::FAULT_W-1:0] fault_reg, fault_next, fault_now;

    logic                 busy_reg, busy_next;
    logic [PAGE_BITS-1:0] page_q_reg;
    logic                 last_q_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 hit_reg, evicted_valid_reg, string_done_reg;
    logic [lru_pr_pkg::SLOT_PORT_W-1:0] frame_slot_reg;
    logic [lru_pr_pkg::PAGE_PORT_W-1:0] evicted_page_reg;
    logic [lru_pr_pkg::FAULT_W-1:0]     fault_total_reg;

    logic accept, proc_fire, do_hit, do_fill, do_evict;
    logic [SLOT_W-1:0] sel_slot, old_rank, new_rank;
    logic [CNT_W-1:0]  new_rank_wide;

    lru_pr_pkg::chain_t   chain      [FRAMES+1];
    logic [SLOT_W-1:0]    hit_slot_c [FRAMES+1];
    logic [SLOT_W-1:0]    hit_rank_c [FRAMES+1];
    logic [SLOT_W-1:0]    empty_slot_c [FRAMES+1];
    logic [SLOT_W-1:0]    lru_slot_c [FRAMES+1];
    logic [PAGE_BITS-1:0] lru_page_c [FRAMES+1];
    logic                 circ_valid [FRAMES];
    logic [SLOT_W-1:0]    circ_rank  [FRAMES];

    // Clamp the written frame count into 1..FRAMES
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_active = CNT_W'(1);
        end
        else if (32'(cfg_wdata) > 32'(FRAMES))
        begin
            cfg_active = CNT_W'(FRAMES);
        end
        else
        begin
            cfg_active = CNT_W'(cfg_wdata);
        end
    end

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        if (cfg_we)
        begin
            state_next = lru_pr_pkg::ST_LOAD;
        end
        else
        begin
            case (state_reg)
                lru_pr_pkg::ST_RUN:   state_next = lru_pr_pkg::ST_RUN;
                lru_pr_pkg::ST_LOAD:  state_next = lru_pr_pkg::ST_SWEEP;
                lru_pr_pkg::ST_SWEEP:
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        state_next = lru_pr_pkg::ST_WRITE;
                    end
                end
                lru_pr_pkg::ST_WRITE: state_next = lru_pr_pkg::ST_RUN;
                default:              state_next = lru_pr_pkg::ST_RUN;
            endcase
        end
    end

    // Sequencer: outputs
    always_comb
    begin
        sweep = '0;
        case (state_reg)
            lru_pr_pkg::ST_LOAD:  sweep.load  = 1'b1;
            lru_pr_pkg::ST_SWEEP: sweep.shift = 1'b1;
            lru_pr_pkg::ST_WRITE: sweep.write = 1'b1;
            default:              sweep       = '0;
        endcase
    end

    always_comb
    begin
        step_next    = step_reg;
        cnt_acc_next = cnt_acc_reg;
        if (sweep.load)
        begin
            step_next    = '0;
            cnt_acc_next = '0;
        end
        else if (sweep.shift)
        begin
            step_next = step_reg + 1'b1;
            if (circ_valid[0])
            begin
                cnt_acc_next = cnt_acc_reg + 1'b1;
            end
        end
    end

    assign active_next = cfg_we ? cfg_active : active_reg;

    // Item handshake: hold one reference while its result is formed
    assign proc_fire = busy_reg && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == lru_pr_pkg::ST_RUN) && (!busy_reg || proc_fire);
    assign accept    = in_valid && in_ready;
    assign busy_next = accept || (busy_reg && !proc_fire);

    // Decision from the end of the frame row
    assign do_hit   = chain[FRAMES].hit;
    assign do_fill  = !do_hit && chain[FRAMES].empty;
    assign do_evict = !do_hit && !chain[FRAMES].empty;

    always_comb
    begin
        if (do_hit)
        begin
            sel_slot = hit_slot_c[FRAMES];
            old_rank = hit_rank_c[FRAMES];
        end
        else if (do_fill)
        begin
            sel_slot = empty_slot_c[FRAMES];
            old_rank = '0;
        end
        else
        begin
            sel_slot = lru_slot_c[FRAMES];
            old_rank = '0;
        end
    end

    assign new_rank_wide = do_fill ? count_reg : (count_reg - 1'b1);
    assign new_rank      = SLOT_W'(new_rank_wide);

    assign cmd.update    = proc_fire;
    assign cmd.promote   = proc_fire && !do_fill;
    assign cmd.clear_all = proc_fire && last_q_reg;

    assign fault_now = (do_hit || (fault_reg == '1)) ? fault_reg : (fault_reg + 1'b1);

    always_comb
    begin
        count_next = count_reg;
        fault_next = fault_reg;
        if (sweep.write)
        begin
            count_next = cnt_acc_reg;
        end
        else if (proc_fire)
        begin
            if (last_q_reg)
            begin
                count_next = '0;
            end
            else if (do_fill)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        if (proc_fire)
        begin
            fault_next = last_q_reg ? '0 : fault_now;
        end
    end

    assign out_valid_next = proc_fire || (out_valid_reg && !out_ready);

    assign chain[0]        = '0;
    assign hit_slot_c[0]   = '0;
    assign hit_rank_c[0]   = '0;
    assign empty_slot_c[0] = '0;
    assign lru_slot_c[0]   = '0;
    assign lru_page_c[0]   = '0;

    for (genvar g = 0; g < FRAMES; g++)
    begin : g_cell
        lru_pr_cell #(
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS),
            .CELL_IDX  (g)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .active         (active_reg),
            .cfg_we         (cfg_we),
            .cfg_active     (cfg_active),
            .page_q         (page_q_reg),
            .chain_in       (chain[g]),
            .hit_slot_in    (hit_slot_c[g]),
            .hit_rank_in    (hit_rank_c[g]),
            .empty_slot_in  (empty_slot_c[g]),
            .lru_slot_in    (lru_slot_c[g]),
            .lru_page_in    (lru_page_c[g]),
            .chain_out      (chain[g+1]),
            .hit_slot_out   (hit_slot_c[g+1]),
            .hit_rank_out   (hit_rank_c[g+1]),
            .empty_slot_out (empty_slot_c[g+1]),
            .lru_slot_out   (lru_slot_c[g+1]),
            .lru_page_out   (lru_page_c[g+1]),
            .cmd            (cmd),
            .cmd_slot       (sel_slot),
            .cmd_old_rank   (old_rank),
            .cmd_new_rank   (new_rank),
            .sweep          (sweep),
            .circ_valid_in  (circ_valid[(g + FRAMES - 1) % FRAMES]),
            .circ_rank_in   (circ_rank[(g + FRAMES - 1) % FRAMES]),
            .circ_valid_out (circ_valid[g]),
            .circ_rank_out  (circ_rank[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lru_pr_pkg::ST_RUN;
            step_reg      <= '0;
            cnt_acc_reg   <= '0;
            count_reg     <= '0;
            active_reg    <= CNT_W'(FRAMES);
            fault_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cnt_acc_reg   <= cnt_acc_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            fault_reg     <= fault_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_q_reg <= PAGE_BITS'(page_number);
            last_q_reg <= last_of_string;
        end
        if (proc_fire)
        begin
            hit_reg           <= do_hit;
            frame_slot_reg    <= lru_pr_pkg::SLOT_PORT_W'(sel_slot);
            evicted_valid_reg <= do_evict;
            evicted_page_reg  <= do_evict ? lru_pr_pkg::PAGE_PORT_W'(lru_page_c[FRAMES]) : '0;
            fault_total_reg   <= fault_now;
            string_done_reg   <= last_q_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_slot    = frame_slot_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_total   = fault_total_reg;
    assign string_done   = string_done_reg;

endmodule

// ===== src/lru_pr_checker.sv =====
// Port-level checker for the LRU page replacement block, bound to the top level
`include "lru_page_replacement_top_macros.svh"

module lru_pr_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                hit,
    input logic [lru_pr_pkg::SLOT_PORT_W-1:0]  frame_slot,
    input logic                                evicted_valid,
    input logic [lru_pr_pkg::PAGE_PORT_W-1:0]  evicted_page,
    input logic [lru_pr_pkg::FAULT_W-1:0]      fault_total
);

    `LRU_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |-> !out_valid, "result shown during reset")

    `LRU_ASSERT_RUN(a_hit_no_evict, out_valid && hit |-> !evicted_valid, "hit reported an eviction")

    `LRU_ASSERT_RUN(a_evict_page_zero, out_valid && !evicted_valid |-> evicted_page == '0, "evicted page set without eviction")

    `LRU_ASSERT_RUN(a_fault_counted, out_valid && !hit |-> fault_total != '0, "fault not counted")

    `LRU_ASSERT_RUN(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(frame_slot) && $stable(fault_total), "stalled result changed")

endmodule

bind lru_page_replacement_top lru_pr_checker u_lru_pr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .frame_slot    (frame_slot),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
);
